// File: design/u2u_pkg.sv
// Shared types and constants for the UTF-8 to UCS-2 stream decoder.
// No dependencies; used by every module of the decoder.
`default_nettype none

package u2u_pkg;

  localparam int unsigned QueueDepth = 2;

  // Lead/continuation masks of the UTF-8 byte layout
  localparam logic [7:0] AsciiLimit = 8'h80;
  localparam logic [7:0] Lead3Mask  = 8'hE0;
  localparam logic [7:0] Lead2Mask  = 8'hC0;

  typedef enum logic [2:0] {
    ClsZero,
    ClsAscii,
    ClsCont,
    ClsLead2,
    ClsLead3
  } byte_class_e;

  typedef struct packed {
    byte_class_e cls;
    logic [7:0]  text_byte;
  } q_entry_t;

endpackage

`default_nettype wire

// File: design/u2u_classify.sv
// Front end: tags each incoming byte with its UTF-8 class before queueing.
// Depends on u2u_pkg.
`default_nettype none

module u2u_classify (
  input  wire logic [7:0]        text_byte_i,
  output u2u_pkg::q_entry_t      entry_o
);

  u2u_pkg::byte_class_e cls;

  always_comb begin
    if (text_byte_i == 8'h00) begin
      cls = u2u_pkg::ClsZero;
    end else if (text_byte_i < u2u_pkg::AsciiLimit) begin
      cls = u2u_pkg::ClsAscii;
    end else if ((text_byte_i & u2u_pkg::Lead3Mask) == u2u_pkg::Lead3Mask) begin
      cls = u2u_pkg::ClsLead3;
    end else if ((text_byte_i & u2u_pkg::Lead2Mask) == u2u_pkg::Lead2Mask) begin
      cls = u2u_pkg::ClsLead2;
    end else begin
      cls = u2u_pkg::ClsCont;
    end
  end

  assign entry_o.cls       = cls;
  assign entry_o.text_byte = text_byte_i;

endmodule

`default_nettype wire

// File: design/u2u_fifo.sv
// Short queue between the classifier and the assembler.
// Depends on u2u_pkg for the entry type.
`default_nettype none

module u2u_fifo #(
  parameter int unsigned Depth = u2u_pkg::QueueDepth
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              push_i,
  input  u2u_pkg::q_entry_t      push_data_i,
  output logic                   full_o,
  input  wire logic              pop_i,
  output logic                   empty_o,
  output u2u_pkg::q_entry_t      head_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  u2u_pkg::q_entry_t mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic            do_push, do_pop;

  assign full_o  = (count_q == CntW'(Depth));
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign head_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

`default_nettype wire

// File: design/u2u_assemble.sv
// Back end: builds code units from queued bytes and holds the output register.
// Depends on u2u_pkg.
`default_nettype none

module u2u_assemble (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              q_valid_i,
  input  u2u_pkg::q_entry_t      q_head_i,
  output logic                   q_pop_o,
  output logic [15:0]            code_unit_o,
  output logic                   end_of_text_o,
  output logic                   dropped_partial_o,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i
);

  logic [1:0]  pending_q, pending_d;
  logic [15:0] partial_q, partial_d;
  logic        out_valid_q;
  logic [15:0] unit_q, unit_d;
  logic        eot_q, eot_d, drop_q, drop_d;
  logic        emit;
  logic        slot_free;
  logic [7:0]  b;

  assign b         = q_head_i.text_byte;
  assign slot_free = !out_valid_q || out_ready_i;
  // beats that produce nothing drain even while the output is stalled
  assign q_pop_o   = q_valid_i && (slot_free || !emit);

  always_comb begin
    pending_d = pending_q;
    partial_d = partial_q;
    emit      = 1'b0;
    unit_d    = '0;
    eot_d     = 1'b0;
    drop_d    = 1'b0;
    if (q_head_i.cls == u2u_pkg::ClsZero) begin
      emit      = 1'b1;
      eot_d     = 1'b1;
      drop_d    = (pending_q != 2'd0);
      pending_d = 2'd0;
      partial_d = '0;
    end else if (pending_q == 2'd0) begin
      unique case (q_head_i.cls)
        u2u_pkg::ClsAscii: begin
          emit   = 1'b1;
          unit_d = {8'h00, b};
        end
        u2u_pkg::ClsLead3: begin
          partial_d = {b[3:0], 12'h000};
          pending_d = 2'd2;
        end
        u2u_pkg::ClsLead2: begin
          partial_d = {5'd0, b[4:0], 6'd0};
          pending_d = 2'd1;
        end
        default: begin
          // stray continuation: skipped
        end
      endcase
    end else if (pending_q != 2'd1) begin
      partial_d = partial_q | {4'd0, b[5:0], 6'd0};
      pending_d = 2'd1;
    end else begin
      emit      = 1'b1;
      unit_d    = partial_q | {10'd0, b[5:0]};
      pending_d = 2'd0;
      partial_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q   <= 2'd0;
      partial_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (q_pop_o) begin
        pending_q <= pending_d;
        partial_q <= partial_d;
      end
      if (q_pop_o && emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o && emit) begin
      unit_q <= unit_d;
      eot_q  <= eot_d;
      drop_q <= drop_d;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign code_unit_o       = unit_q;
  assign end_of_text_o     = eot_q;
  assign dropped_partial_o = drop_q;

endmodule

`default_nettype wire

// File: design/utf8_to_ucs2_stream_decoder.sv
// UTF-8 to UCS-2 stream decoder, top level.
// Path: a code unit's last byte passes through the queue, then the code unit is held in the output register.
// Throughput: one byte per cycle while the queue is not full; the queue and the output register decouple stalls.
// Reset (rst_ni low, asynchronous): queue emptied, no sequence open, no result held.
// Depends on u2u_pkg, u2u_classify, u2u_fifo and u2u_assemble.
`default_nettype none

module utf8_to_ucs2_stream_decoder #(
  parameter int unsigned QueueDepth = u2u_pkg::QueueDepth
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [7:0]  text_byte_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [15:0]      code_unit_o,
  output logic             end_of_text_o,
  output logic             dropped_partial_o
);

  u2u_pkg::q_entry_t cls_entry, q_head;
  logic              q_full, q_empty, q_pop;

  u2u_classify u_classify (
    .text_byte_i (text_byte_i),
    .entry_o     (cls_entry)
  );

  u2u_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (in_valid_i),
    .push_data_i (cls_entry),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .empty_o     (q_empty),
    .head_o      (q_head)
  );

  assign in_ready_o = !q_full;

  u2u_assemble u_assemble (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .q_valid_i         (!q_empty),
    .q_head_i          (q_head),
    .q_pop_o           (q_pop),
    .code_unit_o       (code_unit_o),
    .end_of_text_o     (end_of_text_o),
    .dropped_partial_o (dropped_partial_o),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i)
  );

endmodule

`default_nettype wire
